>>> hdl/cmcn_pkg.sv
// Package: shared types and constants for the cell monitor chain node.
`default_nettype none
package cmcn_pkg;

   typedef enum logic [1:0] {
      OP_COMMAND    = 2'd0,
      OP_TICK       = 2'd1,
      OP_UNEXPECTED = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      KIND_PING    = 3'd0,
      KIND_TEMP    = 3'd1,
      KIND_VOLTAGE = 3'd2,
      KIND_CURRENT = 3'd3,
      KIND_OTHER   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_LOCAL   = 2'd1,
      ACT_FORWARD = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      REG_TEMP_HIGH   = 2'd0,
      REG_TEMP_LOW    = 2'd1,
      REG_VOLTAGE_LOW = 2'd2,
      REG_IDLE_LIMIT  = 2'd3
   } reg_type;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   localparam int LED_GREEN  = 0;
   localparam int LED_YELLOW = 1;
   localparam int LED_RED    = 2;
   localparam int CRIT_VOLT  = 0;
   localparam int CRIT_TEMP  = 1;
   localparam int CRIT_UNEXP = 2;

   localparam logic [9:0]  DAC_MAX      = 10'h3FF;
   localparam logic [9:0]  GREEN_END    = 10'd50;
   localparam logic [9:0]  RED_END      = 10'd500;
   localparam logic [9:0]  MS_PER_S     = 10'd1000;
   localparam logic [2:0]  WATCHDOG_ARM = 3'd5;
   localparam logic [7:0]  REPLY_ACK    = 8'h01;
   localparam logic [7:0]  LEN_SHORT    = 8'd3;
   localparam logic [7:0]  LEN_LONG     = 8'd5;
   localparam logic [2:0]  RLEN_SHORT   = 3'd2;
   localparam logic [2:0]  RLEN_SAMPLE  = 3'd3;
   localparam logic [2:0]  RLEN_LONG    = 3'd4;
   localparam logic [15:0] IDLE_MAX     = 16'hFFFF;

   localparam logic [9:0]  TEMP_HIGH_RESET   = 10'd1023;
   localparam logic [9:0]  TEMP_LOW_RESET    = 10'd0;
   localparam logic [9:0]  VOLTAGE_LOW_RESET = 10'd715;
   localparam logic [15:0] IDLE_LIMIT_RESET  = 16'd10;

endpackage
`default_nettype wire

>>> hdl/cell_monitor_chain_node.sv
// The result register presents a result in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while results are taken; the decode and state update are a single
// combinational pass in front of the result register, which also decouples the sides.
// req_tready drops only while the result register is full and not being taken.
// Synchronous reset clears all node state and restores the limit registers' defaults.
`default_nettype none
module cell_monitor_chain_node (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] command_kind, [10:3] cell_index, [18:11] packet_length,
   // [34:19] current_request, [44:35] temperature_sample, [54:45] voltage_sample
   input  wire logic [cmcn_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] reply_code, [5:3] reply_length, [13:6] sent_byte_one, [21:14] sent_byte_two,
   // [29:22] sent_byte_three, [39:30] dac_code, [40] dac_write, [41] discharging_flag,
   // [44:42] led_state, [47:45] critical_flags, [48] abort_flag
   output logic [cmcn_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] action
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [9:0]  temp_high_ff, temp_low_ff, volt_low_ff;
   logic [15:0] idle_limit_ff;

   logic [9:0]  ms_ff, ms_in, ms_tick;
   logic [15:0] idle_ff, idle_in;
   logic [2:0]  wd_ff, wd_in;
   logic        abort_ff, abort_in;
   logic        dis_ff, dis_in;
   logic [9:0]  cur_ff, cur_in;
   logic [2:0]  crit_ff, crit_in;
   logic [2:0]  led_ff, led_in;

   logic        rsp_valid_ff;
   logic [cmcn_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic        req_fire, csr_write;
   logic [2:0]  kind;
   logic [7:0]  idx, len;
   logic [15:0] cur_req;
   logic [9:0]  tsam, vsam, sample;
   logic        len_ok;
   logic [2:0]  code, rlen;
   logic [7:0]  b1, b2, b3;
   logic        dw;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign kind    = req_tdata[2:0];
   assign idx     = req_tdata[10:3];
   assign len     = req_tdata[18:11];
   assign cur_req = req_tdata[34:19];
   assign tsam    = req_tdata[44:35];
   assign vsam    = req_tdata[54:45];
   assign sample  = (kind == cmcn_pkg::KIND_TEMP) ? tsam : vsam;
   assign len_ok  = (kind <= cmcn_pkg::KIND_CURRENT) &&
                    (len == ((kind == cmcn_pkg::KIND_CURRENT) ? cmcn_pkg::LEN_LONG
                                                               : cmcn_pkg::LEN_SHORT));
   assign ms_tick = ms_ff + 10'd1;

   always_comb begin
      case (cmcn_pkg::reg_type'(csr_paddr[3:2]))
         cmcn_pkg::REG_TEMP_HIGH:   csr_prdata = {22'd0, temp_high_ff};
         cmcn_pkg::REG_TEMP_LOW:    csr_prdata = {22'd0, temp_low_ff};
         cmcn_pkg::REG_VOLTAGE_LOW: csr_prdata = {22'd0, volt_low_ff};
         cmcn_pkg::REG_IDLE_LIMIT:  csr_prdata = {16'd0, idle_limit_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      ms_in    = ms_ff;
      idle_in  = idle_ff;
      wd_in    = wd_ff;
      abort_in = abort_ff;
      dis_in   = dis_ff;
      cur_in   = cur_ff;
      crit_in  = crit_ff;
      led_in   = led_ff;
      rsp_user_in = cmcn_pkg::ACT_NONE;
      code = 3'd0;
      rlen = 3'd0;
      b1   = 8'd0;
      b2   = 8'd0;
      b3   = 8'd0;
      dw   = 1'b0;
      case (cmcn_pkg::op_type'(req_tuser))
         cmcn_pkg::OP_COMMAND: begin
            idle_in  = 16'd0;
            wd_in    = 3'd0;
            abort_in = 1'b0;
            if (len_ok) begin
               code = kind;
               if (idx == 8'd0) begin
                  rsp_user_in = cmcn_pkg::ACT_LOCAL;
                  if (kind == cmcn_pkg::KIND_TEMP || kind == cmcn_pkg::KIND_VOLTAGE) begin
                     if (kind == cmcn_pkg::KIND_TEMP)
                        crit_in[cmcn_pkg::CRIT_TEMP] = (tsam > temp_high_ff) ||
                                                       (tsam < temp_low_ff);
                     else
                        crit_in[cmcn_pkg::CRIT_VOLT] = (vsam < volt_low_ff);
                     rlen = cmcn_pkg::RLEN_SAMPLE;
                     b1   = {6'd0, sample[9:8]};
                     b2   = sample[7:0];
                  end else begin
                     if (kind == cmcn_pkg::KIND_CURRENT) begin
                        dis_in = (cur_req != 16'd0);
                        cur_in = (|cur_req[15:10]) ? cmcn_pkg::DAC_MAX : cur_req[9:0];
                        dw     = 1'b1;
                     end
                     rlen = cmcn_pkg::RLEN_SHORT;
                     b1   = cmcn_pkg::REPLY_ACK;
                  end
               end else begin
                  rsp_user_in = cmcn_pkg::ACT_FORWARD;
                  b1 = idx - 8'd1;
                  if (kind == cmcn_pkg::KIND_CURRENT) begin
                     rlen = cmcn_pkg::RLEN_LONG;
                     b2   = cur_req[15:8];
                     b3   = cur_req[7:0];
                  end else begin
                     rlen = cmcn_pkg::RLEN_SHORT;
                  end
                  wd_in = cmcn_pkg::WATCHDOG_ARM;
               end
            end
         end
         cmcn_pkg::OP_TICK: begin
            ms_in = ms_tick;
            led_in[cmcn_pkg::LED_GREEN] = (ms_tick != 10'd0) &&
                                          (ms_tick < cmcn_pkg::GREEN_END);
            if ((ms_tick != 10'd0) && (ms_tick < cmcn_pkg::RED_END)) begin
               if (dis_ff)
                  led_in[cmcn_pkg::LED_RED] = 1'b1;
            end else begin
               led_in[cmcn_pkg::LED_RED] = 1'b0;
            end
            if (idle_ff > idle_limit_ff) begin
               cur_in = 10'd0;
               dw     = 1'b1;
               dis_in = 1'b0;
               led_in[cmcn_pkg::LED_YELLOW] = 1'b1;
            end else begin
               led_in[cmcn_pkg::LED_YELLOW] = 1'b0;
            end
            if (ms_tick >= cmcn_pkg::MS_PER_S) begin
               ms_in = 10'd0;
               if (idle_ff != cmcn_pkg::IDLE_MAX)
                  idle_in = idle_ff + 16'd1;
               if (wd_ff != 3'd0) begin
                  wd_in = wd_ff - 3'd1;
                  if (wd_ff == 3'd1)
                     abort_in = 1'b1;
               end
            end
            if (crit_ff != 3'd0)
               led_in[cmcn_pkg::LED_RED] = 1'b1;
         end
         cmcn_pkg::OP_UNEXPECTED: begin
            crit_in[cmcn_pkg::CRIT_UNEXP] = 1'b1;
            led_in[cmcn_pkg::LED_RED]     = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_data_in = {7'd0, abort_in, crit_in, led_in, dis_in, dw, cur_in,
                     b3, b2, b1, rlen, code};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_high_ff  <= cmcn_pkg::TEMP_HIGH_RESET;
         temp_low_ff   <= cmcn_pkg::TEMP_LOW_RESET;
         volt_low_ff   <= cmcn_pkg::VOLTAGE_LOW_RESET;
         idle_limit_ff <= cmcn_pkg::IDLE_LIMIT_RESET;
      end else if (csr_write) begin
         case (cmcn_pkg::reg_type'(csr_paddr[3:2]))
            cmcn_pkg::REG_TEMP_HIGH:   temp_high_ff  <= csr_pwdata[9:0];
            cmcn_pkg::REG_TEMP_LOW:    temp_low_ff   <= csr_pwdata[9:0];
            cmcn_pkg::REG_VOLTAGE_LOW: volt_low_ff   <= csr_pwdata[9:0];
            cmcn_pkg::REG_IDLE_LIMIT:  idle_limit_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff    <= 10'd0;
         idle_ff  <= 16'd0;
         wd_ff    <= 3'd0;
         abort_ff <= 1'b0;
         dis_ff   <= 1'b0;
         cur_ff   <= 10'd0;
         crit_ff  <= 3'd0;
         led_ff   <= 3'd0;
      end else if (req_fire) begin
         ms_ff    <= ms_in;
         idle_ff  <= idle_in;
         wd_ff    <= wd_in;
         abort_ff <= abort_in;
         dis_ff   <= dis_in;
         cur_ff   <= cur_in;
         crit_ff  <= crit_in;
         led_ff   <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (req_fire)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while result register stalled");

   a_quiet_when_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == cmcn_pkg::ACT_NONE) |-> (rsp_data_ff[29:0] == 30'd0))
      else $error("packet bytes present with no action");

   a_abort_from_watchdog: assert property (@(posedge clock) disable iff (reset)
      $rose(abort_ff) |-> ($past(wd_ff) == 3'd1))
      else $error("abort set without watchdog expiry");

   a_watchdog_range: assert property (@(posedge clock) disable iff (reset)
      wd_ff <= cmcn_pkg::WATCHDOG_ARM)
      else $error("watchdog beyond armed value");

   a_ms_range: assert property (@(posedge clock) disable iff (reset)
      ms_ff < cmcn_pkg::MS_PER_S)
      else $error("millisecond counter out of range");
`endif

endmodule
`default_nettype wire

>>> bench/tb_cell_monitor_chain_node.sv
// Self-checking testbench for the cell monitor chain node: stream stimulus, predictor, scoreboard.
`timescale 1ns / 1ps
module tb_cell_monitor_chain_node;

   localparam logic [1:0] OP_UNDEFINED    = 2'd3;
   localparam logic [2:0] KIND_UNDEF_LAST = 3'd7;
   localparam int         STALL_LIMIT     = 2000;
   localparam int         LONG_HOLD       = 150;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  kind;
      logic [7:0]  idx;
      logic [7:0]  len;
      logic [15:0] cur;
      logic [9:0]  tsam;
      logic [9:0]  vsam;
   } cell_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] code;
      logic [2:0] rlen;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [9:0] dac;
      logic       dw;
      logic       dis;
      logic [2:0] led;
      logic [2:0] crit;
      logic       abort;
   } node_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [cmcn_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [cmcn_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cell_monitor_chain_node i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the limits and node state
   logic [9:0]  lim_temp_high = cmcn_pkg::TEMP_HIGH_RESET;
   logic [9:0]  lim_temp_low  = cmcn_pkg::TEMP_LOW_RESET;
   logic [9:0]  lim_volt_low  = cmcn_pkg::VOLTAGE_LOW_RESET;
   logic [15:0] lim_idle      = cmcn_pkg::IDLE_LIMIT_RESET;
   logic [9:0]  ms_count  = '0;
   logic [15:0] idle_secs = '0;
   logic [2:0]  wd_secs   = '0;
   logic        abort_q   = 1'b0;
   logic        dis_q     = 1'b0;
   logic [9:0]  dac_q     = '0;
   logic [2:0]  crit_q    = '0;
   logic [2:0]  led_q     = '0;

   cell_cmd_type   pending_cmds[$];
   node_reply_type expected_replies[$];
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             fail_count = 0;

   function automatic node_reply_type step_node(cell_cmd_type c);
      node_reply_type r;
      logic [9:0]     s;
      r = '0;
      if (c.op == cmcn_pkg::OP_COMMAND) begin
         idle_secs = '0;
         wd_secs   = '0;
         abort_q   = 1'b0;
         if (c.kind <= cmcn_pkg::KIND_CURRENT &&
             c.len == ((c.kind == cmcn_pkg::KIND_CURRENT) ? cmcn_pkg::LEN_LONG
                                                          : cmcn_pkg::LEN_SHORT)) begin
            r.code = c.kind;
            if (c.idx == 8'd0) begin
               r.action = cmcn_pkg::ACT_LOCAL;
               if (c.kind == cmcn_pkg::KIND_TEMP || c.kind == cmcn_pkg::KIND_VOLTAGE) begin
                  if (c.kind == cmcn_pkg::KIND_TEMP) begin
                     s = c.tsam;
                     crit_q[cmcn_pkg::CRIT_TEMP] = (c.tsam > lim_temp_high) ||
                                                   (c.tsam < lim_temp_low);
                  end else begin
                     s = c.vsam;
                     crit_q[cmcn_pkg::CRIT_VOLT] = (c.vsam < lim_volt_low);
                  end
                  r.rlen = cmcn_pkg::RLEN_SAMPLE;
                  r.b1   = {6'd0, s[9:8]};
                  r.b2   = s[7:0];
               end else begin
                  if (c.kind == cmcn_pkg::KIND_CURRENT) begin
                     dis_q = (c.cur != 16'd0);
                     dac_q = (c.cur > cmcn_pkg::DAC_MAX) ? cmcn_pkg::DAC_MAX : c.cur[9:0];
                     r.dw  = 1'b1;
                  end
                  r.rlen = cmcn_pkg::RLEN_SHORT;
                  r.b1   = cmcn_pkg::REPLY_ACK;
               end
            end else begin
               r.action = cmcn_pkg::ACT_FORWARD;
               r.b1     = c.idx - 8'd1;
               if (c.kind == cmcn_pkg::KIND_CURRENT) begin
                  r.rlen = cmcn_pkg::RLEN_LONG;
                  r.b2   = c.cur[15:8];
                  r.b3   = c.cur[7:0];
               end else begin
                  r.rlen = cmcn_pkg::RLEN_SHORT;
               end
               wd_secs = cmcn_pkg::WATCHDOG_ARM;
            end
         end
      end else if (c.op == cmcn_pkg::OP_TICK) begin
         ms_count = ms_count + 10'd1;
         led_q[cmcn_pkg::LED_GREEN] = (ms_count > 0) && (ms_count < cmcn_pkg::GREEN_END);
         if (ms_count > 0 && ms_count < cmcn_pkg::RED_END) begin
            if (dis_q)
               led_q[cmcn_pkg::LED_RED] = 1'b1;
         end else begin
            led_q[cmcn_pkg::LED_RED] = 1'b0;
         end
         if (idle_secs > lim_idle) begin
            dac_q = '0;
            r.dw  = 1'b1;
            dis_q = 1'b0;
            led_q[cmcn_pkg::LED_YELLOW] = 1'b1;
         end else begin
            led_q[cmcn_pkg::LED_YELLOW] = 1'b0;
         end
         if (ms_count >= cmcn_pkg::MS_PER_S) begin
            ms_count = '0;
            if (idle_secs < cmcn_pkg::IDLE_MAX)
               idle_secs = idle_secs + 16'd1;
            if (wd_secs > 0) begin
               wd_secs = wd_secs - 3'd1;
               if (wd_secs == 0)
                  abort_q = 1'b1;
            end
         end
         if (crit_q != 0)
            led_q[cmcn_pkg::LED_RED] = 1'b1;
      end else if (c.op == cmcn_pkg::OP_UNEXPECTED) begin
         crit_q[cmcn_pkg::CRIT_UNEXP] = 1'b1;
         led_q[cmcn_pkg::LED_RED]     = 1'b1;
      end
      r.dac   = dac_q;
      r.dis   = dis_q;
      r.led   = led_q;
      r.crit  = crit_q;
      r.abort = abort_q;
      return r;
   endfunction

   function automatic cell_cmd_type make_cmd(logic [1:0] op, logic [2:0] kind, logic [7:0] idx,
                                             logic [7:0] len, logic [15:0] cur,
                                             logic [9:0] tsam, logic [9:0] vsam);
      cell_cmd_type c;
      c.op   = op;
      c.kind = kind;
      c.idx  = idx;
      c.len  = len;
      c.cur  = cur;
      c.tsam = tsam;
      c.vsam = vsam;
      return c;
   endfunction

   function automatic cell_cmd_type cmd_pkt(logic [2:0] kind, logic [7:0] idx, logic [7:0] len,
                                            logic [15:0] cur, logic [9:0] tsam,
                                            logic [9:0] vsam);
      return make_cmd(cmcn_pkg::OP_COMMAND, kind, idx, len, cur, tsam, vsam);
   endfunction

   function automatic cell_cmd_type tick_cmd();
      return make_cmd(cmcn_pkg::OP_TICK, cmcn_pkg::KIND_PING, 8'd0, 8'd0, 16'h0, 10'd0, 10'd0);
   endfunction

   // mostly well-formed commands and ticks, some broken packets and noise
   function automatic cell_cmd_type rand_cmd(bit with_unexp);
      cell_cmd_type c;
      int           pick;
      c.kind = 3'($urandom);
      c.idx  = 8'($urandom);
      c.len  = 8'($urandom);
      c.cur  = 16'($urandom);
      c.tsam = 10'($urandom);
      c.vsam = 10'($urandom);
      pick   = $urandom_range(99);
      if (pick < 45) begin
         c.op = cmcn_pkg::OP_TICK;
      end else if (pick < 85) begin
         c.op   = cmcn_pkg::OP_COMMAND;
         c.kind = 3'($urandom_range(3));
         c.len  = (c.kind == cmcn_pkg::KIND_CURRENT) ? cmcn_pkg::LEN_LONG : cmcn_pkg::LEN_SHORT;
         if ($urandom_range(1))
            c.idx = 8'd0;
         if ($urandom_range(1))
            c.cur = 16'($urandom_range(1100));
      end else if (pick < 95) begin
         c.op = cmcn_pkg::OP_COMMAND;
      end else if (pick < 98 || !with_unexp) begin
         c.op = OP_UNDEFINED;
      end else begin
         c.op = cmcn_pkg::OP_UNEXPECTED;
      end
      return c;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // driver
   cell_cmd_type cur_cmd;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_replies.push_back(step_node(cur_cmd));
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_cmd = pending_cmds.pop_front();
               req_tdata  <= {1'b0, cur_cmd.vsam, cur_cmd.tsam, cur_cmd.cur,
                              cur_cmd.len, cur_cmd.idx, cur_cmd.kind};
               req_tuser  <= cur_cmd.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   int  hold_left = 0;
   int  rsp_count = 0;
   bit  long_hold_done = 0;
   node_reply_type exp_r;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_replies.size() == 0) begin
               $error("result transaction with no expectation waiting");
               fail_count++;
            end else begin
               exp_r = expected_replies.pop_front();
               check_field("action", 32'(exp_r.action), 32'(rsp_tuser));
               check_field("reply_code", 32'(exp_r.code), 32'(rsp_tdata[2:0]));
               check_field("reply_length", 32'(exp_r.rlen), 32'(rsp_tdata[5:3]));
               check_field("sent_byte_one", 32'(exp_r.b1), 32'(rsp_tdata[13:6]));
               check_field("sent_byte_two", 32'(exp_r.b2), 32'(rsp_tdata[21:14]));
               check_field("sent_byte_three", 32'(exp_r.b3), 32'(rsp_tdata[29:22]));
               check_field("dac_code", 32'(exp_r.dac), 32'(rsp_tdata[39:30]));
               check_field("dac_write", 32'(exp_r.dw), 32'(rsp_tdata[40]));
               check_field("discharging_flag", 32'(exp_r.dis), 32'(rsp_tdata[41]));
               check_field("led_state", 32'(exp_r.led), 32'(rsp_tdata[44:42]));
               check_field("critical_flags", 32'(exp_r.crit), 32'(rsp_tdata[47:45]));
               check_field("abort_flag", 32'(exp_r.abort), 32'(rsp_tdata[48]));
            end
         end
         if (!long_hold_done && rsp_count == 40) begin
            long_hold_done = 1;
            hold_left = LONG_HOLD;
         end else if (hold_left == 0 && recv_idle_pct > 0 && $urandom_range(399) == 0) begin
            hold_left = $urandom_range(120, 20);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // stall watchdog
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic csr_write(cmcn_pkg::reg_type r, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (r)
         cmcn_pkg::REG_TEMP_HIGH:   lim_temp_high = value[9:0];
         cmcn_pkg::REG_TEMP_LOW:    lim_temp_low  = value[9:0];
         cmcn_pkg::REG_VOLTAGE_LOW: lim_volt_low  = value[9:0];
         cmcn_pkg::REG_IDLE_LIMIT:  lim_idle      = value[15:0];
         default: begin
         end
      endcase
   endtask

   // sampled between edges so that updates made at the edge are settled
   task automatic drain();
      while (pending_cmds.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limits(logic [9:0] t_high, logic [9:0] t_low, logic [9:0] v_low,
                             logic [15:0] idle);
      drain();
      csr_write(cmcn_pkg::REG_TEMP_HIGH, {22'd0, t_high});
      csr_write(cmcn_pkg::REG_TEMP_LOW, {22'd0, t_low});
      csr_write(cmcn_pkg::REG_VOLTAGE_LOW, {22'd0, v_low});
      csr_write(cmcn_pkg::REG_IDLE_LIMIT, {16'd0, idle});
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass at reset limits
      send_idle_pct = 23;
      recv_idle_pct = 46;
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_PING, 8'd0, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_TEMP, 8'd0, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd1023, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_TEMP, 8'd0, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_VOLTAGE, 8'd0, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_VOLTAGE, 8'd0, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd1023));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_CURRENT, 8'd0, cmcn_pkg::LEN_LONG, 16'hFFFF,
                                     10'd0, 10'd0));
      repeat (3)
         pending_cmds.push_back(tick_cmd());
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_CURRENT, 8'd0, cmcn_pkg::LEN_LONG, 16'd1024,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_CURRENT, 8'd0, cmcn_pkg::LEN_LONG, 16'd0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_CURRENT, 8'd0, cmcn_pkg::LEN_LONG, 16'd700,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_PING, 8'd255, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_TEMP, 8'd1, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_VOLTAGE, 8'd2, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_CURRENT, 8'd1, cmcn_pkg::LEN_LONG, 16'hA5C3,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_PING, 8'd0, 8'd0, 16'h0, 10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_PING, 8'd0, cmcn_pkg::LEN_LONG, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_CURRENT, 8'd0, cmcn_pkg::LEN_SHORT, 16'h3FF,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_TEMP, 8'd0, 8'd255, 16'h0, 10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_OTHER, 8'd0, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(KIND_UNDEF_LAST, 8'd0, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      pending_cmds.push_back(make_cmd(OP_UNDEFINED, cmcn_pkg::KIND_PING, 8'd0,
                                      cmcn_pkg::LEN_SHORT, 16'hFFFF, 10'd1023, 10'd1023));
      repeat (2)
         pending_cmds.push_back(tick_cmd());

      // mid limits, zero idle limit: long tick run passes a second and reaches idle stop
      set_limits(10'd800, 10'd200, 10'd500, 16'd0);
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_CURRENT, 8'd0, cmcn_pkg::LEN_LONG, 16'd300,
                                     10'd0, 10'd0));
      pending_cmds.push_back(cmd_pkt(cmcn_pkg::KIND_PING, 8'd4, cmcn_pkg::LEN_SHORT, 16'h0,
                                     10'd0, 10'd0));
      repeat (1020)
         pending_cmds.push_back(tick_cmd());
      repeat (80)
         pending_cmds.push_back(rand_cmd(0));

      // inverted temperature window, top voltage limit, top idle limit
      set_limits(10'd0, 10'd1023, 10'd1023, 16'hFFFF);
      send_idle_pct = 46;
      recv_idle_pct = 23;
      repeat (90)
         pending_cmds.push_back(rand_cmd(0));

      // widest window, no idling, unexpected interrupts allowed
      set_limits(10'd1023, 10'd0, 10'd0, 16'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pending_cmds.push_back(make_cmd(cmcn_pkg::OP_UNEXPECTED, cmcn_pkg::KIND_PING, 8'd0, 8'd0,
                                      16'h0, 10'd0, 10'd0));
      pending_cmds.push_back(tick_cmd());
      repeat (100)
         pending_cmds.push_back(rand_cmd(1));

      drain();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
